@@ hdl/des_pkg.sv @@
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and round helpers shared by the DES round cells
// and the top level.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned HalfKeyW  = 28;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned RoundKeyW = 48;

  typedef logic [BlockW-1:0]     block_t;
  typedef logic [2*HalfKeyW-1:0] cd_t;
  typedef logic [RoundKeyW-1:0]  rkey_t;

  typedef enum logic {
    ActEncrypt = 1'b0,
    ActDecrypt = 1'b1
  } action_e;

  // Control that travels with each beat through the cell row
  typedef struct packed {
    logic    valid;
    action_e action;
  } cell_ctl_t;

  typedef logic [7:0] tab64_t [64];
  typedef logic [7:0] tab56_t [56];
  typedef logic [7:0] tab48_t [48];
  typedef logic [7:0] tab32_t [32];
  typedef logic [3:0] sbox_t  [8][64];

  localparam tab64_t TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam tab64_t TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam tab48_t TabE = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam tab32_t TabP = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam tab56_t TabPc1 = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam tab48_t TabPc2 = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam sbox_t TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Bit numbering follows the standard: bit 1 is the MSB of the word
  function automatic block_t perm_ip(block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic block_t perm_fp(block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic cd_t perm_pc1(block_t v);
    cd_t r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic rkey_t perm_pc2(cd_t v);
    rkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TabPc2[i])];
    return r;
  endfunction

  // Rotate both 28-bit halves left by the round's shift
  function automatic cd_t rot_cd(cd_t v, logic [1:0] s);
    logic [HalfKeyW-1:0] c;
    logic [HalfKeyW-1:0] d;
    c = v[2*HalfKeyW-1:HalfKeyW];
    d = v[HalfKeyW-1:0];
    if (s == 2'd2) begin
      c = {c[HalfKeyW-3:0], c[HalfKeyW-1:HalfKeyW-2]};
      d = {d[HalfKeyW-3:0], d[HalfKeyW-1:HalfKeyW-2]};
    end else begin
      c = {c[HalfKeyW-2:0], c[HalfKeyW-1]};
      d = {d[HalfKeyW-2:0], d[HalfKeyW-1]};
    end
    return {c, d};
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, rkey_t k);
    rkey_t       e;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
    return p;
  endfunction

endpackage

@@ hdl/des_round_cell.sv @@
// ----------------------------------------------------------------------------
// DES round cell
// One Feistel round. Takes a beat from its left neighbor, applies the round
// key that belongs to this position and passes the registered result on.
// ----------------------------------------------------------------------------
module des_round_cell
  import des_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  cell_ctl_t   ctl_i,
  input  block_t      lr_i,
  input  rkey_t       enc_key_i,
  input  rkey_t       dec_key_i,
  output cell_ctl_t   ctl_o,
  output block_t      lr_o
);

  cell_ctl_t ctl_q;
  block_t    lr_q, lr_d;
  rkey_t     key;

  // Pick key by direction, then run one round
  always_comb begin
    key  = (ctl_i.action == ActDecrypt) ? dec_key_i : enc_key_i;
    lr_d = {lr_i[31:0], lr_i[63:32] ^ feistel(lr_i[31:0], key)};
  end

  // Advance control when the row moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lr_q <= lr_d;
    end
  end

  assign ctl_o = ctl_q;
  assign lr_o  = lr_q;

endmodule

@@ hdl/des_block_cipher.sv @@
// ----------------------------------------------------------------------------
// DES block cipher
// Pipelined DES engine: a row of sixteen round cells, one per Feistel round.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data load the 64-bit key. Write it only while
//   the engine is empty; round keys are derived from it and registered,
//   so let the key and then the round-key registers update before sending a block.
//   s_axis carries one block per beat: tdata = data_block, tuser = action
//   (0 encrypt, 1 decrypt). m_axis returns one result block per beat.
// Path: the first cell loads an accepted input beat on the accepting edge,
//   then the beat passes through fifteen more cells and the output register
//   to m_axis.
// Throughput: one block per cycle when not stalled; the row moves in lockstep.
// Stall: while the output register holds an untaken result, the whole row
//   and the output register hold, and s_axis_tready is low in that same
//   cycle (it follows m_axis_tready combinationally).
// Reset: clears the key to zero and empties the row and output register.
// ----------------------------------------------------------------------------
module des_block_cipher
  import des_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,       // key_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_block
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // out_block
);

  block_t    key_q;
  rkey_t     rkey_q [NumRounds];
  cd_t       cd     [NumRounds+1];
  cell_ctl_t ctl    [NumRounds+1];
  block_t    lr     [NumRounds+1];
  logic      out_valid_q;
  block_t    out_q;
  logic      adv;

  assign cfg_ready = 1'b1;

  // Hold the key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid) begin
      key_q <= cfg_data;
    end
  end

  // Derive and register the round keys
  assign cd[0] = perm_pc1(key_q);
  for (genvar g = 0; g < NumRounds; g++) begin : g_ks
    assign cd[g+1] = rot_cd(cd[g], TabRot[g]);
    always_ff @(posedge clk_i) begin
      rkey_q[g] <= perm_pc2(cd[g+1]);
    end
  end

  // Row moves unless the output register holds a beat that cannot leave
  assign adv           = !(out_valid_q && !m_axis_tready);
  assign s_axis_tready = adv;

  assign ctl[0].valid  = s_axis_tvalid;
  assign ctl[0].action = action_e'(s_axis_tuser);
  assign lr[0]         = perm_ip(s_axis_tdata);

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    des_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ctl_i     (ctl[g]),
      .lr_i      (lr[g]),
      .enc_key_i (rkey_q[g]),
      .dec_key_i (rkey_q[NumRounds-1-g]),
      .ctl_o     (ctl[g+1]),
      .lr_o      (lr[g+1])
    );
  end

  // Output register with final swap and permutation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl[NumRounds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= perm_fp({lr[NumRounds][31:0], lr[NumRounds][63:32]});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Stalled result must persist
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  // Input is refused only when output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without stall");

  // Last cell valid reaches output after an advance
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ctl[NumRounds].valid |=> out_valid_q)
    else $error("beat lost at output");

endmodule

@@ verif/des_block_cipher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DES block cipher testbench
// Drives directed vectors, then random encrypt/decrypt blocks, under several
// keys; predicts unknown results with a behavioral DES in the bench and
// compares each output beat in order. Both sides idle at random save one key.
// ----------------------------------------------------------------------------
module des_block_cipher_test;
  import des_pkg::*;

  localparam int unsigned Latency = 17;
  localparam int unsigned KeyWait = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // data_block
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // out_block

  block_t      cipher_key;
  block_t      expected_blocks[$];
  int unsigned mismatch_count;
  bit          idle_free;
  bit          sink_ready;

  // Directed rows: key, action, data, known, expected (used only if known)
  typedef struct {
    block_t  key;
    action_e act;
    block_t  data;
    bit      known;
    block_t  result;
  } vector_t;

  des_block_cipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Hard stop
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Bit p counts from 1 at the MSB of a w-bit word
  function automatic bit pick(logic [63:0] v, int w, int p);
    return v[w-p];
  endfunction

  function automatic logic [31:0] round_mix(logic [31:0] r, rkey_t k);
    rkey_t       ex;
    logic [31:0] sb;
    logic [31:0] pm;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) ex[47-i] = pick(r, 32, TabE[i]);
    ex ^= k;
    for (int i = 0; i < 8; i++) begin
      six = ex[47-6*i -: 6];
      sb[31-4*i -: 4] = TabS[i][{six[5], six[0]} * 16 + six[4:1]];
    end
    for (int i = 0; i < 32; i++) pm[31-i] = pick(sb, 32, TabP[i]);
    return pm;
  endfunction

  function automatic block_t des_compute(block_t key, action_e act, block_t din);
    rkey_t               sub[16];
    logic [27:0]         c, d;
    logic [55:0]         cd;
    block_t              b, o;
    logic [31:0]         l, r, t;
    for (int i = 0; i < 56; i++) cd[55-i] = pick(key, 64, TabPc1[i]);
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      repeat (TabRot[i]) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      for (int j = 0; j < 48; j++) sub[i][47-j] = pick({c, d}, 56, TabPc2[j]);
    end
    for (int i = 0; i < 64; i++) b[63-i] = pick(din, 64, TabIp[i]);
    l = b[63:32];
    r = b[31:0];
    for (int i = 0; i < 16; i++) begin
      t = l ^ round_mix(r, (act == ActDecrypt) ? sub[15-i] : sub[i]);
      l = r;
      r = t;
    end
    for (int i = 0; i < 64; i++) o[63-i] = pick({r, l}, 64, TabFp[i]);
    return o;
  endfunction

  task automatic report_mismatch(string what, block_t got, block_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Load the key; engine must be empty
  task automatic load_key(block_t k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cipher_key = k;
    repeat (KeyWait) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Send one beat, with random idle cycles ahead of it unless idle_free is set
  task automatic send_block(action_e act, block_t data, bit known, block_t result);
    while (!idle_free && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_blocks.push_back(known ? result : des_compute(cipher_key, act, data));
  endtask

  // Sink: random stalls unless idle_free, in-order compare
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, '0);
      end else begin
        if (m_axis_tdata !== expected_blocks[0])
          report_mismatch("out_block", m_axis_tdata, expected_blocks[0]);
        void'(expected_blocks.pop_front());
      end
    end
    m_axis_tready <= idle_free || ($urandom_range(99) >= 15);
  end

  initial begin
    vector_t     vecs[$];
    block_t      keys[6];
    block_t      pt, ct;
    int unsigned wait_cycles;
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cipher_key    = '0;
    idle_free     = 1'b0;
    mismatch_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key of zero, then the textbook vector, weak keys, extremes
    vecs.push_back('{64'h0, ActEncrypt, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7});
    vecs.push_back('{64'h0, ActDecrypt, 64'h8CA64DE9C1B123A7, 1'b1, 64'h0});
    vecs.push_back('{64'h0, ActEncrypt, '1, 1'b0, '0});
    vecs.push_back('{64'h133457799BBCDFF1, ActEncrypt, 64'h0123456789ABCDEF, 1'b1,
                     64'h85E813540F0AB405});
    vecs.push_back('{64'h133457799BBCDFF1, ActDecrypt, 64'h85E813540F0AB405, 1'b1,
                     64'h0123456789ABCDEF});
    vecs.push_back('{64'h133457799BBCDFF1, ActDecrypt, 64'h0, 1'b0, '0});
    vecs.push_back('{'1, ActEncrypt, '1, 1'b1, 64'h7359B2163E4EDC58});
    vecs.push_back('{'1, ActDecrypt, '1, 1'b0, '0});
    vecs.push_back('{'1, ActEncrypt, 64'h0, 1'b0, '0});
    vecs.push_back('{64'h0101010101010101, ActEncrypt, 64'h95F8A5E5DD31D900, 1'b1,
                     64'h8000000000000000});
    vecs.push_back('{64'h0101010101010101, ActDecrypt, 64'h8000000000000000, 1'b1,
                     64'h95F8A5E5DD31D900});
    vecs.push_back('{64'h01FE01FE01FE01FE, ActEncrypt, 64'h5555AAAA5555AAAA, 1'b0, '0});
    vecs.push_back('{64'hFEFEFEFEFEFEFEFE, ActDecrypt, 64'hAAAA5555AAAA5555, 1'b0, '0});
    vecs.push_back('{64'h8000000000000001, ActEncrypt, 64'h8000000000000001, 1'b0, '0});

    // Walk the table; reload the key between groups with the engine empty
    foreach (vecs[i]) begin
      if (vecs[i].key != cipher_key) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        load_key(vecs[i].key);
      end
      send_block(vecs[i].act, vecs[i].data, vecs[i].known, vecs[i].result);
    end
    s_axis_tvalid <= 1'b0;

    // Random part: several keys, extremes included
    keys = '{64'h0, '1, 64'h0, 64'h0, 64'h0, 64'h0};
    for (int k = 2; k < 6; k++) keys[k] = {$urandom, $urandom};
    for (int k = 0; k < 6; k++) begin
      wait_drained();
      load_key(keys[k]);
      idle_free = (k == 3);
      for (int n = 0; n < 65; n++) begin
        pt = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
          // Encrypt then decrypt the known result back
          ct = des_compute(cipher_key, ActEncrypt, pt);
          send_block(ActEncrypt, pt, 1'b0, '0);
          send_block(ActDecrypt, ct, 1'b1, pt);
        end else begin
          send_block(action_e'($urandom_range(1)), pt, 1'b0, '0);
        end
        if (n == 40) begin
          // Hold off until the engine is empty
          s_axis_tvalid <= 1'b0;
          while (expected_blocks.size() != 0) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b0;
    end
    idle_free = 1'b0;

    wait_cycles = 0;
    while (expected_blocks.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
